[rtl/dsp_multiply_saturate_unit_top_defines.svh]
// assertion macros shared by the dsp multiply-saturate unit
`ifndef DSP_MULTIPLY_SATURATE_UNIT_TOP_DEFINES_SVH
`define DSP_MULTIPLY_SATURATE_UNIT_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define DMSU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dmsu assertion failed");

// next-cycle implication, disabled while reset is low
`define DMSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dmsu assertion failed");

`endif

[rtl/dmsu_pkg.sv]
// types and operation codes of the dsp multiply-saturate unit
package dmsu_pkg;

    // operation codes
    typedef enum logic [3:0] {
        OP_SMLAXY  = 4'd0,
        OP_SMLAWY  = 4'd1,
        OP_SMULWY  = 4'd2,
        OP_SMLALXY = 4'd3,
        OP_SMULXY  = 4'd4,
        OP_QADD    = 4'd5,
        OP_QSUB    = 4'd6,
        OP_QDADD   = 4'd7,
        OP_QDSUB   = 4'd8,
        OP_CLZ     = 4'd9
    } t_op;

    // one instruction
    typedef struct packed {
        logic [3:0]  operation;
        logic        select_x;
        logic        select_y;
        logic [31:0] value_m;
        logic [31:0] value_s;
        logic [31:0] value_n;
        logic [31:0] value_high;
        logic        condition_passed;
    } t_in_item;

    // one result
    typedef struct packed {
        logic [31:0] result_main;
        logic [31:0] result_low;
        logic        write_main;
        logic        write_low;
        logic        saturated_now;
        logic        q_flag;
    } t_out_item;

    // datapath result before the sticky flag is merged
    typedef struct packed {
        logic [31:0] result_main;
        logic [31:0] result_low;
        logic        write_main;
        logic        write_low;
        logic        saturated_now;
    } t_exec_res;

endpackage

[rtl/dmsu_if.sv]
// valid/ready channels for instructions and results
interface dmsu_in_if
    import dmsu_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface dmsu_out_if
    import dmsu_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[rtl/dsp_multiply_saturate_unit_top.sv]
// top level of the dsp multiply-saturate unit
// Executes the ARMv5TE DSP instructions (SMLAxy, SMLAWy, SMULWy, SMLALxy,
// SMULxy, QADD, QSUB, QDADD, QDSUB, CLZ) and keeps the sticky Q flag, which
// each result reports as it stands after that instruction. An instruction
// transfers on i_in and its result reaches o_out through the input register
// and then the result register; one instruction is taken every cycle while
// o_out keeps up. One 32x16 multiplier and the 64-bit accumulate adder lie
// between the two registers. A failed condition or an unknown
// operation code still yields a result, with both writes and saturated_now low
// and q_flag showing the unchanged sticky Q.
module dsp_multiply_saturate_unit_top
    import dmsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    dmsu_in_if.sink    i_in,
    dmsu_out_if.source o_out
);

`include "dsp_multiply_saturate_unit_top_defines.svh"

    logic      s1_valid;
    t_in_item  s1_item;
    t_exec_res ex_res;
    logic      s2_ready;
    logic      sticky_q;

    // input register
    dmsu_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_ready (s2_ready),
        .o_valid (s1_valid),
        .o_item  (s1_item)
    );

    // datapath
    dmsu_exec u_exec (
        .i_item (s1_item),
        .o_res  (ex_res)
    );

    // result register
    dmsu_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s1_valid),
        .i_res      (ex_res),
        .o_ready    (s2_ready),
        .o_out      (o_out),
        .o_sticky_q (sticky_q)
    );

    // sticky q never clears
    `DMSU_ASSERT_NEXT(a_q_sticky, i_clk, i_rst_n, sticky_q, sticky_q)
    // a saturating result always reports q set
    `DMSU_ASSERT_NOW(a_sat_sets_q, i_clk, i_rst_n,
        o_out.valid && o_out.payload.saturated_now, o_out.payload.q_flag)
    // low word writes only with a non-saturating main write
    `DMSU_ASSERT_NOW(a_low_with_main, i_clk, i_rst_n,
        o_out.valid && o_out.payload.write_low,
        o_out.payload.write_main && !o_out.payload.saturated_now)

endmodule

[rtl/dmsu_in_stage.sv]
// input register stage: captures one instruction per transfer
module dmsu_in_stage
    import dmsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    dmsu_in_if.sink    i_in,
    input  logic       i_ready,
    output logic       o_valid,
    output t_in_item   o_item
);

    logic     r_valid;
    t_in_item r_item;

    // stage frees when empty or when the result stage takes it
    assign i_in.ready = !r_valid || i_ready;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item <= i_in.payload;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[rtl/dmsu_exec.sv]
// combinational datapath: halfword multiplies, saturating adds, leading zero count
module dmsu_exec
    import dmsu_pkg::*;
(
    input  t_in_item  i_item,
    output t_exec_res o_res
);

    localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;
    localparam logic [5:0]  CLZ_ZERO = 6'd32;

    // leading zeros by halving search, zero source handled outside
    function automatic logic [5:0] f_clz(input logic [31:0] v);
        logic [31:0] w;
        logic [5:0]  n;
        w = v;
        n = 6'd0;
        if (w[31:16] == 16'd0) begin n = n + 6'd16; w = {w[15:0], 16'd0}; end
        if (w[31:24] == 8'd0)  begin n = n + 6'd8;  w = {w[23:0], 8'd0};  end
        if (w[31:28] == 4'd0)  begin n = n + 6'd4;  w = {w[27:0], 4'd0};  end
        if (w[31:30] == 2'd0)  begin n = n + 6'd2;  w = {w[29:0], 2'd0};  end
        if (!w[31])            begin n = n + 6'd1;                        end
        return n;
    endfunction

    logic signed [15:0] hs;
    logic signed [15:0] hm;
    logic signed [31:0] mul_a;
    logic signed [47:0] prod;
    logic        [31:0] prod_lo;
    logic        [31:0] prod_w;
    logic        [31:0] acc_add;
    logic        [32:0] acc_sum;
    logic               acc_ovf;
    logic        [63:0] long_sum;
    logic               dbl_ovf;
    logic        [31:0] dbl_val;
    logic        [31:0] q_b;
    logic               q_sub;
    logic        [32:0] q_sum;
    logic               q_ovf;
    logic        [31:0] q_res;
    logic               wide_op;
    logic               dbl_op;

    // halfword selection
    assign hs = i_item.select_y ? i_item.value_s[31:16] : i_item.value_s[15:0];
    assign hm = i_item.select_x ? i_item.value_m[31:16] : i_item.value_m[15:0];

    // one shared 32x16 signed multiplier; word forms use all of rm
    assign wide_op = (i_item.operation == OP_SMLAWY) || (i_item.operation == OP_SMULWY);
    assign mul_a   = wide_op ? $signed(i_item.value_m) : 32'(hm);
    assign prod    = mul_a * hs;
    assign prod_lo = prod[31:0];
    assign prod_w  = prod[47:16];

    // 32-bit accumulate with signed overflow detect
    assign acc_add = wide_op ? prod_w : prod_lo;
    assign acc_sum = {acc_add[31], acc_add} + {i_item.value_n[31], i_item.value_n};
    assign acc_ovf = acc_sum[32] ^ acc_sum[31];

    // 64-bit accumulate for the long form
    assign long_sum = {i_item.value_high, i_item.value_n} + {{32{prod_lo[31]}}, prod_lo};

    // doubling of rn with saturation
    assign dbl_op  = (i_item.operation == OP_QDADD) || (i_item.operation == OP_QDSUB);
    assign dbl_ovf = i_item.value_n[31] ^ i_item.value_n[30];
    assign dbl_val = dbl_ovf ? (i_item.value_n[31] ? SAT_MIN : SAT_MAX)
                             : {i_item.value_n[30:0], 1'b0};
    assign q_b     = dbl_op ? dbl_val : i_item.value_n;

    // saturating add or subtract
    assign q_sub = (i_item.operation == OP_QSUB) || (i_item.operation == OP_QDSUB);
    assign q_sum = q_sub ? ({i_item.value_m[31], i_item.value_m} - {q_b[31], q_b})
                         : ({i_item.value_m[31], i_item.value_m} + {q_b[31], q_b});
    assign q_ovf = q_sum[32] ^ q_sum[31];
    assign q_res = q_ovf ? (q_sum[32] ? SAT_MIN : SAT_MAX) : q_sum[31:0];

    // result selection by operation
    always_comb begin
        o_res = '0;
        if (i_item.condition_passed) begin
            case (i_item.operation)
                OP_SMLAXY, OP_SMLAWY: begin
                    o_res.result_main   = acc_sum[31:0];
                    o_res.write_main    = 1'b1;
                    o_res.saturated_now = acc_ovf;
                end
                OP_SMULWY: begin
                    o_res.result_main = prod_w;
                    o_res.write_main  = 1'b1;
                end
                OP_SMULXY: begin
                    o_res.result_main = prod_lo;
                    o_res.write_main  = 1'b1;
                end
                OP_SMLALXY: begin
                    o_res.result_main = long_sum[63:32];
                    o_res.result_low  = long_sum[31:0];
                    o_res.write_main  = 1'b1;
                    o_res.write_low   = 1'b1;
                end
                OP_QADD, OP_QSUB, OP_QDADD, OP_QDSUB: begin
                    o_res.result_main   = q_res;
                    o_res.write_main    = 1'b1;
                    o_res.saturated_now = q_ovf || (dbl_op && dbl_ovf);
                end
                OP_CLZ: begin
                    o_res.result_main = {26'd0, (i_item.value_m == 32'd0)
                                                ? CLZ_ZERO : f_clz(i_item.value_m)};
                    o_res.write_main  = 1'b1;
                end
                default: begin
                    o_res = '0;
                end
            endcase
        end
    end

endmodule

[rtl/dmsu_out_stage.sv]
// result register stage and sticky q flag
module dmsu_out_stage
    import dmsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_exec_res  i_res,
    output logic       o_ready,
    dmsu_out_if.source o_out,
    output logic       o_sticky_q
);

    logic      r_valid;
    logic      r_q;
    t_out_item r_item;
    logic      n_q;
    logic      load;

    // result register frees when empty or when its result transfers
    assign o_ready = !r_valid || o_out.ready;
    assign load    = i_valid && o_ready;

    // q is set by any saturating operation and never cleared
    assign n_q = r_q || (load && i_res.saturated_now);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_q     <= 1'b0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            r_q <= n_q;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= {i_res.result_main, i_res.result_low, i_res.write_main,
                       i_res.write_low, i_res.saturated_now, n_q};
        end
    end

    assign o_out.valid   = r_valid;
    assign o_out.payload = r_item;
    assign o_sticky_q    = r_q;

endmodule

[tb/sv/dmsu_result_checker.sv]
// result checker for the dsp multiply-saturate unit: predicts each result and compares it
`timescale 1ns / 100ps

module dmsu_result_checker
    import dmsu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_item,
    output int        o_fail_count,
    output int        o_pending
);

    localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
    localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

    t_out_item expected_results[$];
    logic      q_state = 1'b0;
    int        fail_total = 0;

    // sign-extend a register value
    function automatic logic signed [63:0] widen(logic [31:0] w);
        return 64'($signed(w));
    endfunction

    // chosen halfword, sign-extended
    function automatic logic signed [63:0] signed_half(logic [31:0] w, logic top);
        logic [15:0] h;
        h = top ? w[31:16] : w[15:0];
        return 64'($signed(h));
    endfunction

    // signed 32-bit saturation, flag in the top bit
    function automatic logic [32:0] clamp32(logic signed [63:0] v);
        if (v > SAT_HI) begin
            return {1'b1, 32'h7fff_ffff};
        end
        if (v < SAT_LO) begin
            return {1'b1, 32'h8000_0000};
        end
        return {1'b0, v[31:0]};
    endfunction

    // expected result of one instruction, given the sticky flag before it
    function automatic t_out_item predict_dsp_result(t_in_item ins, logic q_in);
        t_out_item          res;
        logic signed [63:0] half_m;
        logic signed [63:0] half_s;
        logic signed [63:0] prod;
        logic signed [63:0] total;
        logic signed [63:0] op_a;
        logic signed [63:0] op_b;
        logic [63:0]        acc;
        logic [32:0]        clamped;
        logic               sat;
        int                 zeros;
        res    = '0;
        sat    = 1'b0;
        half_m = signed_half(ins.value_m, ins.select_x);
        half_s = signed_half(ins.value_s, ins.select_y);
        if (ins.condition_passed) begin
            case (ins.operation)
                OP_SMLAXY, OP_SMULXY: begin
                    prod  = half_m * half_s;
                    total = prod + widen(ins.value_n);
                    if (ins.operation == OP_SMLAXY) begin
                        sat             = (total > SAT_HI) || (total < SAT_LO);
                        res.result_main = total[31:0];
                    end else begin
                        res.result_main = prod[31:0];
                    end
                    res.write_main = 1'b1;
                end
                OP_SMLAWY, OP_SMULWY: begin
                    // bits 47..16 of the 48-bit product
                    prod  = widen(ins.value_m) * half_s;
                    op_a  = widen(prod[47:16]);
                    total = op_a + widen(ins.value_n);
                    if (ins.operation == OP_SMLAWY) begin
                        sat             = (total > SAT_HI) || (total < SAT_LO);
                        res.result_main = total[31:0];
                    end else begin
                        res.result_main = op_a[31:0];
                    end
                    res.write_main = 1'b1;
                end
                OP_SMLALXY: begin
                    // 64-bit accumulate, wraps without flags
                    prod            = half_m * half_s;
                    acc             = {ins.value_high, ins.value_n} + prod;
                    res.result_main = acc[63:32];
                    res.result_low  = acc[31:0];
                    res.write_main  = 1'b1;
                    res.write_low   = 1'b1;
                end
                OP_QADD, OP_QSUB, OP_QDADD, OP_QDSUB: begin
                    op_a = widen(ins.value_m);
                    op_b = widen(ins.value_n);
                    // doubling saturates on its own
                    if (ins.operation == OP_QDADD || ins.operation == OP_QDSUB) begin
                        clamped = clamp32(op_b * 2);
                        sat     = clamped[32];
                        op_b    = widen(clamped[31:0]);
                    end
                    if (ins.operation == OP_QADD || ins.operation == OP_QDADD) begin
                        clamped = clamp32(op_a + op_b);
                    end else begin
                        clamped = clamp32(op_a - op_b);
                    end
                    sat             = sat | clamped[32];
                    res.result_main = clamped[31:0];
                    res.write_main  = 1'b1;
                end
                OP_CLZ: begin
                    zeros = 0;
                    for (int i = 31; i >= 0; i--) begin
                        if (ins.value_m[i]) begin
                            break;
                        end
                        zeros++;
                    end
                    res.result_main = 32'(zeros);
                    res.write_main  = 1'b1;
                end
                default: begin
                    // unknown codes leave everything low
                end
            endcase
        end
        res.saturated_now = sat;
        res.q_flag        = q_in | sat;
        return res;
    endfunction

    // one line per mismatch, and count it
    task automatic note_mismatch(string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        fail_total++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            note_mismatch($sformatf("%s got %08h wanted %08h", name, got, want));
        end
    endtask

    // compare result transfers, then predict from instruction transfers
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            expected_results.delete();
            q_state = 1'b0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    note_mismatch("result transfer with no instruction outstanding");
                end else begin
                    want = expected_results.pop_front();
                    check_field("result_main", i_out_item.result_main, want.result_main);
                    check_field("result_low", i_out_item.result_low, want.result_low);
                    check_field("write_main", 32'(i_out_item.write_main), 32'(want.write_main));
                    check_field("write_low", 32'(i_out_item.write_low), 32'(want.write_low));
                    check_field("saturated_now", 32'(i_out_item.saturated_now),
                                32'(want.saturated_now));
                    check_field("q_flag", 32'(i_out_item.q_flag), 32'(want.q_flag));
                end
            end
            if (i_in_valid && i_in_ready) begin
                want    = predict_dsp_result(i_in_item, q_state);
                q_state = want.q_flag;
                expected_results.push_back(want);
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= fail_total;
    end

endmodule

[tb/sv/dsp_multiply_saturate_unit_top_tb.sv]
// testbench top for the dsp multiply-saturate unit: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module dsp_multiply_saturate_unit_top_tb;
    import dmsu_pkg::*;

    localparam logic [3:0] OP_UNUSED_LO = 4'd10;
    localparam logic [3:0] OP_UNUSED_HI = 4'd15;
    localparam int         RANDOM_ITEMS = 500;
    localparam int         HOLD_AT      = 200;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         LIMIT_CYCLES = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   sent_count = 0;
    int   cycle_count = 0;
    int   fail_count;
    int   pending;

    dmsu_in_if  in_ch ();
    dmsu_out_if out_ch ();

    dsp_multiply_saturate_unit_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    dmsu_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_ch.valid),
        .i_in_ready   (in_ch.ready),
        .i_in_item    (in_ch.payload),
        .i_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .i_out_item   (out_ch.payload),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 10 ns clock
    always #5 i_clk = ~i_clk;

    function automatic t_in_item make_instr(logic [3:0] op, logic sel_x, logic sel_y,
                                            logic [31:0] m, logic [31:0] s, logic [31:0] n,
                                            logic [31:0] hi, logic cond);
        t_in_item it;
        it.operation        = op;
        it.select_x         = sel_x;
        it.select_y         = sel_y;
        it.value_m          = m;
        it.value_s          = s;
        it.value_n          = n;
        it.value_high       = hi;
        it.condition_passed = cond;
        return it;
    endfunction

    // register values weighted towards the edges of the range
    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            2: return 32'h7fff_ffff;
            3: return 32'h8000_0000;
            4: return 32'($signed($urandom_range(0, 511)) - 256);
            5: return {($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000,
                       ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'hffff};
            default: return $urandom();
        endcase
    endfunction

    function automatic t_in_item random_instruction();
        logic [3:0] op;
        if ($urandom_range(0, 19) == 0) begin
            op = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        end else begin
            op = 4'($urandom_range(OP_SMLAXY, OP_CLZ));
        end
        return make_instr(op, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          random_word(), random_word(), random_word(), random_word(),
                          $urandom_range(0, 9) != 0);
    endfunction

    // offer one instruction and hold it until it transfers
    task automatic send_instr(t_in_item it);
        in_ch.valid   <= 1'b1;
        in_ch.payload <= it;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
        sent_count++;
    endtask

    // receiver: stall pattern of its own, plus one long hold-off
    initial begin : receiver
        int  mode_left;
        int  ready_pct;
        int  hold_left;
        bit  hold_done;
        mode_left = 0;
        ready_pct = 100;
        hold_left = 0;
        hold_done = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!hold_done && sent_count >= HOLD_AT) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (mode_left == 0) begin
                mode_left = $urandom_range(10, 60);
                case ($urandom_range(0, 3))
                    0: ready_pct = 100;
                    1: ready_pct = 70;
                    2: ready_pct = 40;
                    default: ready_pct = 10;
                endcase
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(1, 100) <= ready_pct);
            end
        end
    end

    // cycle limit
    initial begin : watchdog
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // reset, stimulus and verdict
    initial begin : stimulus
        t_in_item instrs[$];
        int       idx;
        int       burst;
        int       gap;
        in_ch.valid   <= 1'b0;
        in_ch.payload <= '0;
        i_rst_n       <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: quiet cases first so a clear Q is seen
        instrs.push_back(make_instr(OP_SMULXY, 1'b0, 1'b0, 32'h0000_7fff, 32'h0000_7fff,
                                    32'h0, 32'h0, 1'b1));
        instrs.push_back(make_instr(OP_SMULXY, 1'b1, 1'b1, 32'h8000_0000, 32'h8000_ffff,
                                    32'h0, 32'h0, 1'b1));
        instrs.push_back(make_instr(OP_SMLAXY, 1'b0, 1'b1, 32'hffff_8000, 32'h8000_0000,
                                    32'h0000_0001, 32'h0, 1'b1));
        instrs.push_back(make_instr(OP_SMULWY, 1'b0, 1'b1, 32'h8000_0000, 32'h8000_0000,
                                    32'h0, 32'h0, 1'b1));
        instrs.push_back(make_instr(OP_SMLALXY, 1'b1, 1'b0, 32'h7fff_0000, 32'h0000_8000,
                                    32'hffff_ffff, 32'h7fff_ffff, 1'b1));
        instrs.push_back(make_instr(OP_SMLALXY, 1'b0, 1'b0, 32'h0000_7fff, 32'h0000_8000,
                                    32'h0, 32'h8000_0000, 1'b1));
        instrs.push_back(make_instr(OP_CLZ, 1'b1, 1'b1, 32'h0, 32'hffff_ffff,
                                    32'h0, 32'h0, 1'b1));
        instrs.push_back(make_instr(OP_CLZ, 1'b0, 1'b0, 32'hffff_ffff, 32'h0,
                                    32'h0, 32'h0, 1'b1));
        instrs.push_back(make_instr(OP_CLZ, 1'b0, 1'b0, 32'h0000_0001, 32'h0,
                                    32'h0, 32'h0, 1'b1));
        instrs.push_back(make_instr(OP_QADD, 1'b1, 1'b0, 32'h0000_0001, 32'h0,
                                    32'h0000_0002, 32'h0, 1'b1));
        // failed condition on a saturating add, and an unknown code
        instrs.push_back(make_instr(OP_QADD, 1'b0, 1'b0, 32'h7fff_ffff, 32'h0,
                                    32'h0000_0001, 32'h0, 1'b0));
        instrs.push_back(make_instr(OP_UNUSED_HI, 1'b1, 1'b1, 32'hffff_ffff, 32'hffff_ffff,
                                    32'hffff_ffff, 32'hffff_ffff, 1'b1));
        // saturation of the q ops, both directions
        instrs.push_back(make_instr(OP_QSUB, 1'b0, 1'b0, 32'h0, 32'h0,
                                    32'h8000_0000, 32'h0, 1'b1));
        instrs.push_back(make_instr(OP_QADD, 1'b0, 1'b0, 32'h7fff_ffff, 32'h0,
                                    32'h7fff_ffff, 32'h0, 1'b1));
        instrs.push_back(make_instr(OP_QSUB, 1'b0, 1'b0, 32'h8000_0000, 32'h0,
                                    32'h0000_0001, 32'h0, 1'b1));
        // doubling saturates, then exact doubling with a saturating subtract
        instrs.push_back(make_instr(OP_QDADD, 1'b0, 1'b0, 32'h0, 32'h0,
                                    32'h4000_0000, 32'h0, 1'b1));
        instrs.push_back(make_instr(OP_QDSUB, 1'b0, 1'b0, 32'h0, 32'h0,
                                    32'hc000_0000, 32'h0, 1'b1));
        instrs.push_back(make_instr(OP_QDADD, 1'b0, 1'b0, 32'h8000_0000, 32'h0,
                                    32'h8000_0000, 32'h0, 1'b1));
        instrs.push_back(make_instr(OP_QDSUB, 1'b0, 1'b0, 32'h7fff_ffff, 32'h0,
                                    32'h7fff_ffff, 32'h0, 1'b1));
        // accumulate overflow wraps and flags
        instrs.push_back(make_instr(OP_SMLAXY, 1'b0, 1'b0, 32'h0000_8000, 32'h0000_8000,
                                    32'h7fff_ffff, 32'h0, 1'b1));
        instrs.push_back(make_instr(OP_SMLAWY, 1'b0, 1'b0, 32'h7fff_ffff, 32'h0000_7fff,
                                    32'h7fff_ffff, 32'h0, 1'b1));
        instrs.push_back(make_instr(OP_SMLAWY, 1'b1, 1'b1, 32'h8000_0000, 32'h7fff_0000,
                                    32'h8000_0000, 32'h0, 1'b1));
        instrs.push_back(make_instr(OP_SMULWY, 1'b1, 1'b0, 32'hffff_ffff, 32'hffff_ffff,
                                    32'h0, 32'h0, 1'b1));
        instrs.push_back(make_instr(OP_UNUSED_LO, 1'b0, 1'b0, 32'h1234_5678, 32'h0,
                                    32'h0, 32'h0, 1'b1));
        instrs.push_back(make_instr(OP_SMLALXY, 1'b1, 1'b1, 32'hffff_ffff, 32'hffff_ffff,
                                    32'hffff_ffff, 32'hffff_ffff, 1'b0));

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            instrs.push_back(random_instruction());
        end

        // bursts of transfers with random gaps between them
        idx = 0;
        while (idx < instrs.size()) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && idx < instrs.size(); k++) begin
                send_instr(instrs[idx]);
                idx++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0 && idx < instrs.size()) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        in_ch.valid <= 1'b0;

        // drain
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
